/* hw/rtl/pkbd_pkg.sv */
`default_nettype none
package pkbd_pkg;

  // widths of the segment size register and the byte counter
  localparam int SEG_W = 25;

  // command queue depth between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  // segment end status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC_LIT = 2'd1,
    ST_NO_REPEAT = 2'd2,
    ST_SIZE_ERR  = 2'd3
  } status_t;

  // one decoded run handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;  // byte to emit
    logic [7:0] nbytes;     // how many copies, 0..128
    logic       last;       // segment ends with this item
    status_t    status;     // valid when last
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/pkbd_cmd_queue.sv */
`default_nettype none
module pkbd_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  pkbd_pkg::cmd_t     push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output pkbd_pkg::cmd_t     head_cmd
);
  import pkbd_pkg::*;

  cmd_t              mem [CQ_DEPTH];
  logic [CQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CQ_AW:0]    count_r, count_nxt;

  assign full       = (count_r == (CQ_AW+1)'(CQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pkbd_front.sv */
`default_nettype none
module pkbd_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // size register write
  input  wire logic                   cfg_we,
  input  wire logic [pkbd_pkg::SEG_W-1:0] cfg_data,
  // compressed byte stream
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             code_byte,
  input  wire logic                   segment_last,
  // command queue side
  input  wire logic                   cq_full,
  output logic                        cq_push,
  output pkbd_pkg::cmd_t              cq_cmd
);
  import pkbd_pkg::*;

  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_REP  = 2'd2
  } mode_t;

  localparam logic [7:0] CTRL_NOP = 8'h80;

  mode_t            mode_r, mode_nxt;
  logic [7:0]       lit_left_r, lit_left_nxt;
  logic [7:0]       rep_cnt_r, rep_cnt_nxt;
  logic [SEG_W-1:0] produced_r, produced_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SEG_W-1:0] seg_bytes_r;

  logic             accept;
  logic             has_room;
  logic [SEG_W-1:0] room;
  logic [7:0]       nbytes;
  status_t          status;

  assign in_ready = !cq_full;
  assign accept   = in_valid && !cq_full;
  assign has_room = (produced_r < seg_bytes_r);
  assign room     = has_room ? (seg_bytes_r - produced_r) : '0;

  // decode one compressed byte
  always_comb begin
    mode_nxt     = mode_r;
    lit_left_nxt = lit_left_r;
    rep_cnt_nxt  = rep_cnt_r;
    ovf_nxt      = ovf_r;
    nbytes       = '0;
    unique case (mode_r)
      MODE_LIT: begin
        if (has_room) begin
          nbytes = 8'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
        lit_left_nxt = lit_left_r - 8'd1;
        if (lit_left_nxt == 8'd0) begin
          mode_nxt = MODE_CTRL;
        end
      end
      MODE_REP: begin
        // clip the run at the remaining room
        nbytes      = ({{(SEG_W-8){1'b0}}, rep_cnt_r} < room) ? rep_cnt_r : room[7:0];
        rep_cnt_nxt = '0;
        mode_nxt    = MODE_CTRL;
      end
      default: begin
        if (has_room) begin
          if (!code_byte[7]) begin
            mode_nxt     = MODE_LIT;
            lit_left_nxt = code_byte + 8'd1;
          end else if (code_byte != CTRL_NOP) begin
            mode_nxt    = MODE_REP;
            rep_cnt_nxt = 8'(9'd257 - {1'b0, code_byte});
          end
        end
      end
    endcase
    produced_nxt = produced_r + {{(SEG_W-8){1'b0}}, nbytes};
  end

  // end of segment status, in priority order
  always_comb begin
    if (mode_nxt == MODE_LIT) begin
      status = ST_TRUNC_LIT;
    end else if (mode_nxt == MODE_REP) begin
      status = ST_NO_REPEAT;
    end else if (produced_nxt != seg_bytes_r || ovf_nxt) begin
      status = ST_SIZE_ERR;
    end else begin
      status = ST_OK;
    end
  end

  // quiet bytes leave nothing for the back end
  assign cq_push          = accept && (segment_last || nbytes != 8'd0);
  assign cq_cmd.data_byte = code_byte;
  assign cq_cmd.nbytes    = nbytes;
  assign cq_cmd.last      = segment_last;
  assign cq_cmd.status    = segment_last ? status : ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_CTRL;
      lit_left_r  <= '0;
      rep_cnt_r   <= '0;
      produced_r  <= '0;
      ovf_r       <= 1'b0;
      seg_bytes_r <= '0;
    end else begin
      if (cfg_we) begin
        seg_bytes_r <= cfg_data;
      end
      if (accept) begin
        if (segment_last) begin
          mode_r     <= MODE_CTRL;
          lit_left_r <= '0;
          rep_cnt_r  <= '0;
          produced_r <= '0;
          ovf_r      <= 1'b0;
        end else begin
          mode_r     <= mode_nxt;
          lit_left_r <= lit_left_nxt;
          rep_cnt_r  <= rep_cnt_nxt;
          produced_r <= produced_nxt;
          ovf_r      <= ovf_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pkbd_back.sv */
`default_nettype none
module pkbd_back #(
  parameter int LANES = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // command queue side
  input  wire logic         cq_valid,
  input  pkbd_pkg::cmd_t    cq_cmd,
  output logic              cq_pop,
  // result beats
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       out_data,
  output logic [2:0]        out_count,
  output logic              item_done,
  output logic              segment_done,
  output pkbd_pkg::status_t status
);
  import pkbd_pkg::*;

  localparam logic [7:0] LANES_B = 8'(LANES);

  // run in progress
  logic       cur_valid_r, cur_valid_nxt;
  cmd_t       cur_r, cur_nxt;
  logic [7:0] rem_r, rem_nxt;

  // output register
  logic       out_valid_r;
  logic [31:0] data_r;
  logic [2:0] count_r;
  logic       item_done_r, seg_done_r;
  status_t    status_r;

  logic       out_free, fire, fin;
  logic [2:0] cnt;
  logic [31:0] beat_data;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = cur_valid_r && out_free;
  assign fin      = (rem_r <= LANES_B);
  assign cnt      = fin ? rem_r[2:0] : LANES_B[2:0];
  assign cq_pop   = cq_valid && (!cur_valid_r || (fire && fin));

  // replicate the byte over the valid lanes
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      beat_data[8*i +: 8] = (3'(i) < cnt) ? cur_r.data_byte : 8'd0;
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    if (fire) begin
      rem_nxt = rem_r - {5'd0, cnt};
      if (fin) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (cq_pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = cq_cmd;
      rem_nxt       = cq_cmd.nbytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    rem_r <= rem_nxt;
    if (fire) begin
      data_r      <= beat_data;
      count_r     <= cnt;
      item_done_r <= fin;
      seg_done_r  <= fin && cur_r.last;
      status_r    <= (fin && cur_r.last) ? cur_r.status : ST_OK;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = data_r;
  assign out_count    = count_r;
  assign item_done    = item_done_r;
  assign segment_done = seg_done_r;
  assign status       = status_r;

endmodule
`default_nettype wire

/* hw/rtl/packbits_segment_decoder_unit.sv */
`default_nettype none
// Channel | Direction | Handshake             | Payload
// in      | slave     | in_tvalid / in_tready | in_tdata[7:0] code byte, in_tlast segment end
// out     | master    | out_tvalid/out_tready | out_tdata data/count/item_done, out_tlast,
//         |           |                       | out_tuser status
// cfg     | slave     | cfg_valid / cfg_ready | cfg_data segment size (always ready)
//
// The front end decodes one compressed byte per cycle while the command queue has room
// and queues run commands. The back end emits one beat per cycle while out_tready is
// high, ceil(n / lanes) beats per run, so a 128-byte repeat at four lanes yields 32
// beats; input stalls only when the four-entry command queue fills. Reset (rst_n low,
// synchronous) clears the decode state, the queue and the size register to zero.
module packbits_segment_decoder_unit #(
  parameter int OUT_LANES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] code_byte
  input  wire logic        in_tlast,   // segment_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] out_data, [34:32] out_count,
                                       // [35] item_done, [39:36] zero
  output logic             out_tlast,  // segment_done
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [24:0] cfg_data    // segment_bytes
);
  import pkbd_pkg::*;

  localparam int BEAT_LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);

  logic       cq_full, cq_push, cq_pop, cq_valid;
  cmd_t       push_cmd, head_cmd;
  logic [31:0] out_data;
  logic [2:0] out_count;
  logic       item_done;
  status_t    status;

  assign cfg_ready = 1'b1;

  pkbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .code_byte    (in_tdata),
    .segment_last (in_tlast),
    .cq_full      (cq_full),
    .cq_push      (cq_push),
    .cq_cmd       (push_cmd)
  );

  pkbd_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cq_push),
    .push_cmd   (push_cmd),
    .full       (cq_full),
    .pop        (cq_pop),
    .head_valid (cq_valid),
    .head_cmd   (head_cmd)
  );

  pkbd_back #(
    .LANES (BEAT_LANES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cq_valid     (cq_valid),
    .cq_cmd       (head_cmd),
    .cq_pop       (cq_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_data),
    .out_count    (out_count),
    .item_done    (item_done),
    .segment_done (out_tlast),
    .status       (status)
  );

  assign out_tdata = {4'd0, item_done, out_count, out_data};
  assign out_tuser = status;

endmodule
`default_nettype wire

/* sim/packbits_segment_decoder_unit_tb.sv */
`timescale 1ns / 100ps
module packbits_segment_decoder_unit_tb;
  import pkbd_pkg::*;

  localparam int         LANES         = 4;
  localparam logic [7:0] CTRL_NOP      = 8'h80;
  localparam logic [24:0] SIZE_MAX     = 25'd16777216;
  localparam int         MAX_GAP       = 13;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         CYCLE_LIMIT   = 600000;
  localparam int         RANDOM_ITEMS  = 180;
  localparam int         MAX_PRINTS    = 40;

  typedef enum logic [1:0] {
    DEC_CTRL    = 2'd0,
    DEC_LITERAL = 2'd1,
    DEC_REPEAT  = 2'd2
  } dec_mode_t;

  // one decoded beat as the block should present it
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        item_done;
    logic        seg_done;
    status_t     status;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [24:0] cfg_data;

  // decoder image kept by the testbench
  dec_mode_t   dec_mode;
  logic [7:0]  lit_left;
  logic [7:0]  rep_len;
  logic [24:0] produced;
  bit          overflow;
  logic [24:0] seg_size;

  beat_t       beat_q[$];
  logic [7:0]  seg_seq[$];

  bit          steady;
  int          errors;
  int          cycles;
  int          beats_seen;
  int          items_sent;
  int          items_live;
  int          segments;
  int          size_writes;
  int          rdy_hold;
  int          gap_draw;

  packbits_segment_decoder_unit #(
    .OUT_LANES(LANES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    if (steady) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    // past the cap, mismatches are still counted
    if (errors <= MAX_PRINTS)
      $display("MISMATCH beat %0d: %s got 0x%0h want 0x%0h", beats_seen, what, got, want);
  endtask

  // decode one code byte and queue the beats it should produce
  task automatic decode_byte(input logic [7:0] b, input logic last, output bit ignored);
    int      nbytes;
    int      room;
    int      beats;
    int      left;
    int      cnt;
    status_t st;
    beat_t   bt;
    nbytes  = 0;
    ignored = 1'b0;
    st      = ST_OK;
    case (dec_mode)
      DEC_LITERAL: begin
        if (produced < seg_size) begin
          nbytes = 1;
          produced++;
        end else begin
          overflow = 1'b1;
        end
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) dec_mode = DEC_CTRL;
      end
      DEC_REPEAT: begin
        room     = (produced < seg_size) ? int'(seg_size - produced) : 0;
        nbytes   = (int'(rep_len) < room) ? int'(rep_len) : room;
        produced = produced + 25'(nbytes);
        rep_len  = 8'd0;
        dec_mode = DEC_CTRL;
      end
      default: begin
        if (produced < seg_size) begin
          if (b < CTRL_NOP) begin
            dec_mode = DEC_LITERAL;
            lit_left = b + 8'd1;
          end else if (b != CTRL_NOP) begin
            dec_mode = DEC_REPEAT;
            rep_len  = 8'(9'd257 - {1'b0, b});
          end
        end else begin
          // segment already full: control bytes fall through
          ignored = !last;
        end
      end
    endcase

    if (last) begin
      if (dec_mode == DEC_LITERAL) st = ST_TRUNC_LIT;
      else if (dec_mode == DEC_REPEAT) st = ST_NO_REPEAT;
      else if (produced != seg_size || overflow) st = ST_SIZE_ERR;
      else st = ST_OK;
    end

    beats = (nbytes + LANES - 1) / LANES;
    if (beats == 0 && last) beats = 1;
    left = nbytes;
    for (int k = 0; k < beats; k++) begin
      cnt          = (left < LANES) ? left : LANES;
      bt.data      = '0;
      for (int i = 0; i < cnt; i++) bt.data[8*i +: 8] = b;
      bt.count     = 3'(cnt);
      bt.item_done = (k == beats - 1);
      bt.seg_done  = (k == beats - 1) && last;
      bt.status    = bt.seg_done ? st : ST_OK;
      beat_q = {beat_q, bt};
      left -= cnt;
    end

    if (last) begin
      dec_mode = DEC_CTRL;
      lit_left = 8'd0;
      rep_len  = 8'd0;
      produced = '0;
      overflow = 1'b0;
    end
  endtask

  // hand one code byte to the block
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    bit ignored;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    decode_byte(b, last, ignored);
    items_sent++;
    if (!ignored) items_live++;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold input until all results are out and the front end has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [24:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seg_size = v;
    size_writes++;
  endtask

  // well-formed runs totaling n or n+1 decoded bytes, with a few no-ops
  task automatic append_runs(input int n);
    int rem;
    int len;
    int cap;
    rem = n;
    while (rem > 0) begin
      if ($urandom_range(0, 7) == 0) seg_seq = {seg_seq, CTRL_NOP};
      cap = (rem < 128) ? rem : 128;
      if ($urandom_range(0, 3) != 0) cap = (cap < 8) ? cap : 8;
      if ($urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, cap);
        seg_seq = {seg_seq, 8'(len - 1)};
        repeat (len) seg_seq = {seg_seq, 8'($urandom)};
      end else begin
        len = $urandom_range(2, (cap < 2) ? 2 : cap);
        seg_seq = {seg_seq, 8'(257 - len)};
        seg_seq = {seg_seq, 8'($urandom)};
      end
      rem -= len;
    end
  endtask

  // size zero after reset: segment end with nothing decoded
  task automatic test_empty_segment();
    send_byte(8'h05, 1'b1);
  endtask

  // literal, short repeat, no-op and a longer literal filling the size exactly
  task automatic test_mixed_runs();
    set_size(25'd6);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(CTRL_NOP, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  // 128-byte repeat, short of the size
  task automatic test_longest_repeat();
    set_size(25'd200);
    send_byte(8'h81, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_truncated_literal();
    set_size(25'd4);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
  endtask

  task automatic test_missing_repeat_byte();
    set_size(25'd4);
    send_byte(8'hFE, 1'b1);
  endtask

  // literal runs past the size: extra bytes suppressed, flagged at the end
  task automatic test_literal_overflow();
    set_size(25'd2);
    send_byte(8'h03, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
  endtask

  // clipped repeat, ignored control once full, then a larger size mid-segment
  task automatic test_full_and_resize();
    set_size(25'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h00, 1'b0);
    set_size(25'd3);
    send_byte(8'hFD, 1'b0);
    send_byte(8'h99, 1'b1);
  endtask

  task automatic test_random_segments();
    int          kind;
    int          plan;
    int          cut;
    int          base;
    logic [24:0] v;
    base = items_live;
    set_size(25'd24);
    while (items_live < base + RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       v = 25'd0;
          1:       v = SIZE_MAX;
          2:       v = 25'($urandom_range(60, 160));
          3:       v = 25'($urandom_range(0, 16777216));
          default: v = 25'($urandom_range(1, 48));
        endcase
        set_size(v);
      end
      steady = ($urandom_range(0, 3) == 0);
      plan = (seg_size <= 25'd600) ? int'(seg_size) : $urandom_range(1, 48);
      seg_seq.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // noise
        repeat ($urandom_range(1, 12)) seg_seq = {seg_seq, 8'($urandom)};
      end else begin
        append_runs(plan + ((kind == 8) ? $urandom_range(1, 20) : 0));
        // broken: segment ends early, often mid-run
        if (kind == 7 && seg_seq.size() > 1) begin
          cut = $urandom_range(1, seg_seq.size() - 1);
          while (seg_seq.size() > cut) void'(seg_seq.pop_back());
        end
      end
      if (seg_seq.size() == 0) seg_seq = {seg_seq, 8'($urandom)};
      foreach (seg_seq[i]) send_byte(seg_seq[i], i == seg_seq.size() - 1);
      segments++;
    end
    steady = 1'b0;
  endtask

  // result side stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rdy_hold   <= 0;
    end else if (out_tvalid && out_tready) begin
      gap_draw = draw_gap();
      out_tready <= (gap_draw == 0);
      rdy_hold   <= gap_draw;
    end else if (!out_tready) begin
      if (rdy_hold <= 1) out_tready <= 1'b1;
      rdy_hold <= rdy_hold - 1;
    end
  end

  // compare every accepted beat with the oldest pending one
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (beat_q.size() == 0) begin
        report_mismatch("result with no item pending, data", out_tdata[31:0], 32'd0);
      end else begin
        want = beat_q.pop_front();
        if (out_tdata[31:0] !== want.data)
          report_mismatch("out_data", out_tdata[31:0], want.data);
        if (out_tdata[34:32] !== want.count)
          report_mismatch("out_count", 32'(out_tdata[34:32]), 32'(want.count));
        if (out_tdata[35] !== want.item_done)
          report_mismatch("item_done", 32'(out_tdata[35]), 32'(want.item_done));
        if (out_tlast !== want.seg_done)
          report_mismatch("segment_done", 32'(out_tlast), 32'(want.seg_done));
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, beat_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 25'd0;
    steady    = 1'b0;
    dec_mode  = DEC_CTRL;
    lit_left  = 8'd0;
    rep_len   = 8'd0;
    produced  = '0;
    overflow  = 1'b0;
    seg_size  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_segment();
    test_mixed_runs();
    test_longest_repeat();
    test_truncated_literal();
    test_missing_repeat_byte();
    test_literal_overflow();
    test_full_and_resize();
    test_random_segments();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d code bytes in %0d random segments plus directed runs, %0d size writes",
             items_sent, segments, size_writes);
    $display("Checked %0d result beats, %0d mismatches", beats_seen, errors);
    if (errors == 0 && beat_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* packbits_segment_decoder_unit.f */
hw/rtl/pkbd_pkg.sv
hw/rtl/pkbd_cmd_queue.sv
hw/rtl/pkbd_front.sv
hw/rtl/pkbd_back.sv
hw/rtl/packbits_segment_decoder_unit.sv
sim/packbits_segment_decoder_unit_tb.sv
